/* rtl/core/pke_pkg.sv */
`default_nettype none

package pke_pkg;

  localparam int unsigned FREQ_W        = 17;
  localparam int unsigned COPIES_W      = 16;
  localparam int unsigned KIN_W         = 24;
  localparam int unsigned PSUM_W        = 48;
  localparam int unsigned VSUM_W        = 40;
  localparam int unsigned PROD_W        = 36;
  localparam int unsigned VAR_W         = 34;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);

  localparam logic [FREQ_W-1:0] ONE_Q16 = FREQ_W'(65536);

  typedef struct packed {
    logic [FREQ_W-1:0]   freq_first;
    logic [FREQ_W-1:0]   freq_second;
    logic [FREQ_W-1:0]   ref_freq;
    logic [COPIES_W-1:0] gene_copies;
    logic                data_missing;
    logic                last_allele;
  } pke_in_t;

  typedef struct packed {
    logic signed [KIN_W-1:0] kinship;
    logic                    locus_missing;
    logic                    zero_denominator;
  } pke_out_t;

  // one finished locus handed from the front to the divider
  typedef struct packed {
    logic signed [PSUM_W-1:0] psum;
    logic [VSUM_W-1:0]        vsum;
    logic [COPIES_W-1:0]      copies;
    logic                     missing;
  } pke_rec_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } pke_qstat_t;

  function automatic logic [FREQ_W-1:0] clamp_freq(input logic [FREQ_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pke_front.sv */
`default_nettype none

module pke_front import pke_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire pke_in_t    item_i,
  input  wire pke_qstat_t qstat_i,
  output logic            wr_o,
  output pke_rec_t        rec_o
);

  logic                      a_vld_q;
  logic signed [PROD_W-1:0]  a_prod_q, a_prod_d;
  logic [VAR_W-1:0]          a_var_q, a_var_d;
  logic [COPIES_W-1:0]       a_copies_q;
  logic                      a_miss_q, a_last_q;

  logic signed [PSUM_W-1:0]  psum_q, psum_sat;
  logic [VSUM_W-1:0]         vsum_q, vsum_sat;
  logic                      miss_q;

  logic [FREQ_W-1:0]         fa, fb, fp;
  logic signed [FREQ_W:0]    da, db;
  logic signed [PSUM_W:0]    psum_sum;
  logic [VSUM_W:0]           vsum_sum;
  logic                      accept;

  assign full_o = (qstat_i.count + QCNT_W'(a_vld_q && a_last_q)) >= QCNT_W'(QDEPTH);
  assign accept = push_i && !full_o;

  always_comb begin
    fa       = clamp_freq(item_i.freq_first);
    fb       = clamp_freq(item_i.freq_second);
    fp       = clamp_freq(item_i.ref_freq);
    da       = $signed({1'b0, fa}) - $signed({1'b0, fp});
    db       = $signed({1'b0, fb}) - $signed({1'b0, fp});
    a_prod_d = da * db;
    a_var_d  = VAR_W'(fp) * VAR_W'(ONE_Q16 - fp);
  end

  always_comb begin
    psum_sum = $signed({psum_q[PSUM_W-1], psum_q})
             + $signed({{(PSUM_W + 1 - PROD_W){a_prod_q[PROD_W-1]}}, a_prod_q});
    if (psum_sum[PSUM_W] != psum_sum[PSUM_W-1]) begin
      psum_sat = psum_sum[PSUM_W] ? {1'b1, {(PSUM_W-1){1'b0}}} : {1'b0, {(PSUM_W-1){1'b1}}};
    end else begin
      psum_sat = psum_sum[PSUM_W-1:0];
    end
    vsum_sum = {1'b0, vsum_q} + (VSUM_W + 1)'(a_var_q);
    vsum_sat = vsum_sum[VSUM_W] ? {VSUM_W{1'b1}} : vsum_sum[VSUM_W-1:0];
  end

  assign wr_o          = a_vld_q && a_last_q;
  assign rec_o.psum    = psum_sat;
  assign rec_o.vsum    = vsum_sat;
  assign rec_o.copies  = a_copies_q;
  assign rec_o.missing = miss_q || a_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      psum_q  <= '0;
      vsum_q  <= '0;
      miss_q  <= 1'b0;
    end else begin
      a_vld_q <= accept;
      if (a_vld_q) begin
        if (a_last_q) begin
          psum_q <= '0;
          vsum_q <= '0;
          miss_q <= 1'b0;
        end else begin
          psum_q <= psum_sat;
          vsum_q <= vsum_sat;
          miss_q <= miss_q || a_miss_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_prod_q   <= a_prod_d;
      a_var_q    <= a_var_d;
      a_copies_q <= item_i.gene_copies;
      a_miss_q   <= item_i.data_missing;
      a_last_q   <= item_i.last_allele;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pke_fifo.sv */
`default_nettype none

module pke_fifo import pke_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire pke_rec_t wr_data_i,
  input  wire logic     rd_i,
  output pke_rec_t      rd_data_o,
  output pke_qstat_t    stat_o
);

  pke_rec_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign rd_data_o    = mem_q[rptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(wr_i) - QCNT_W'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pke_back.sv */
`default_nettype none

module pke_back import pke_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pke_rec_t   rec_i,
  input  wire pke_qstat_t qstat_i,
  output logic            rd_o,
  output pke_out_t        result_o,
  output logic            empty_o,
  input  wire logic       pop_i
);

  localparam int unsigned T_W  = PSUM_W + 1;
  localparam int unsigned DW   = T_W + FRAC_BITS;
  localparam int unsigned CW   = $clog2(DW + 1);
  localparam int unsigned RW   = VSUM_W + 1;
  localparam int unsigned SATB = KIN_W - 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CORR = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_KIN  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [DW-1:0]            dvd_q, dvd_d;
  logic [VSUM_W-1:0]        dsr_q, dsr_d;
  logic [RW-1:0]            rem_q, rem_d, rem_sh;
  logic [VSUM_W-1:0]        quot_q, quot_d;
  logic                     ovf_q, ovf_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic signed [PSUM_W-1:0] psum_q, psum_d;
  logic [VSUM_W-1:0]        vsum_q, vsum_d;
  logic signed [T_W-1:0]    t_q, t_d;
  logic                     neg_q, neg_d;
  logic                     miss_q, miss_d, zden_q, zden_d;
  pke_out_t                 out_q, out_d;
  logic                     out_vld_q, out_vld_d;
  logic [COPIES_W-1:0]      divisor;
  logic                     ge, sat;
  logic [KIN_W-1:0]         mag;
  logic [T_W-1:0]           tabs;

  assign result_o = out_q;
  assign empty_o  = !out_vld_q;

  always_comb begin
    divisor = (rec_i.copies < COPIES_W'(2)) ? COPIES_W'(1) : rec_i.copies - COPIES_W'(1);
    rem_sh  = {rem_q[RW-2:0], dvd_q[DW-1]};
    ge      = rem_sh >= {1'b0, dsr_q};
    sat     = ovf_q || (quot_q[VSUM_W-1:SATB] != '0);
    mag     = {1'b0, quot_q[SATB-1:0]};
    tabs    = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
  end

  always_comb begin
    state_d   = state_q;
    dvd_d     = dvd_q;
    dsr_d     = dsr_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    psum_d    = psum_q;
    vsum_d    = vsum_q;
    t_d       = t_q;
    neg_d     = neg_q;
    miss_d    = miss_q;
    zden_d    = zden_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop_i;
    rd_o      = 1'b0;
    unique case (state_q) inside
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          rd_o   = 1'b1;
          psum_d = rec_i.psum;
          vsum_d = rec_i.vsum;
          miss_d = rec_i.missing;
          zden_d = !rec_i.missing && (rec_i.vsum == '0);
          quot_d = '0;
          ovf_d  = 1'b0;
          neg_d  = 1'b0;
          if (rec_i.missing || rec_i.vsum == '0) begin
            state_d = ST_FIN;
          end else begin
            dvd_d   = {rec_i.vsum, {(DW - VSUM_W){1'b0}}};
            dsr_d   = VSUM_W'(divisor);
            rem_d   = '0;
            cnt_d   = CW'(VSUM_W);
            state_d = ST_CORR;
          end
        end
      end
      ST_CORR, ST_KIN: begin
        dvd_d  = dvd_q << 1;
        rem_d  = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
        quot_d = {quot_q[VSUM_W-2:0], ge};
        ovf_d  = ovf_q || quot_q[VSUM_W-1];
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = (state_q == ST_CORR) ? ST_SUM : ST_FIN;
        end
      end
      ST_SUM: begin
        t_d     = $signed({psum_q[PSUM_W-1], psum_q}) + $signed({1'b0, quot_q});
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        neg_d   = t_q[T_W-1];
        dvd_d   = {tabs, {FRAC_BITS{1'b0}}};
        dsr_d   = vsum_q;
        rem_d   = '0;
        quot_d  = '0;
        ovf_d   = 1'b0;
        cnt_d   = CW'(DW);
        state_d = ST_KIN;
      end
      ST_FIN: begin
        if (!out_vld_q || pop_i) begin
          out_vld_d              = 1'b1;
          out_d.locus_missing    = miss_q;
          out_d.zero_denominator = zden_q;
          if (sat) begin
            out_d.kinship = neg_q ? {1'b1, {SATB{1'b0}}} : {1'b0, {SATB{1'b1}}};
          end else begin
            out_d.kinship = neg_q ? -$signed(mag) : $signed(mag);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
    psum_q <= psum_d;
    vsum_q <= vsum_d;
    t_q    <= t_d;
    neg_q  <= neg_d;
    miss_q <= miss_d;
    zden_q <= zden_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

/* rtl/core/pairwise_kinship_estimator_top.sv */
// channel   direction  handshake            payload
// items     in         push / full          item_i   (pke_in_t)
// results   out        empty / pop          result_o (pke_out_t)
//
// Alleles are taken one per cycle unless full: multiply stage, then running sums.
// The last allele of a locus drops a record into a 4-entry queue.
// A shared 1-bit-per-cycle divider then runs two divisions for each valid locus
// (setup, correction, sum, load, kinship, output); flagged loci go to output.
// full rises when the queue cannot take another locus; results wait in an
// output register while the next locus is divided. Reset clears all control.
`default_nettype none

module pairwise_kinship_estimator_top import pke_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  output logic         full,
  input  wire pke_in_t item_i,
  output logic         empty,
  input  wire logic    pop,
  output pke_out_t     result_o
);

  pke_qstat_t qstat;
  pke_rec_t   wr_rec, rd_rec;
  logic       q_wr, q_rd;

  pke_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (item_i),
    .qstat_i (qstat),
    .wr_o    (q_wr),
    .rec_o   (wr_rec)
  );

  pke_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (wr_rec),
    .rd_i      (q_rd),
    .rd_data_o (rd_rec),
    .stat_o    (qstat)
  );

  pke_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_i    (rd_rec),
    .qstat_i  (qstat),
    .rd_o     (q_rd),
    .result_o (result_o),
    .empty_o  (empty),
    .pop_i    (pop)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("locus queue overflow");

  a_full_when_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count == QCNT_W'(QDEPTH) |-> full)
    else $error("input open while locus queue is full");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.locus_missing && result_o.zero_denominator))
    else $error("both invalid flags set");

  a_flagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.locus_missing || result_o.zero_denominator))
      |-> result_o.kinship == '0)
    else $error("flagged locus carries an estimate");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pke_pkg::*;

  localparam int FRAC          = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int HOLD_CYCLES   = 3000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam longint PSUM_HI   = 64'sd140737488355327;
  localparam longint PSUM_LO   = -64'sd140737488355328;
  localparam longint unsigned VSUM_HI = 64'd1099511627775;
  localparam longint KIN_HI    = 64'sd8388607;
  localparam longint KIN_LO    = -64'sd8388608;

  class kinship_scoreboard;
    longint          product_acc = 0;
    longint unsigned variance_acc = 0;
    bit              missing_acc = 0;
    pke_out_t        loci_due[$];
    int              errors = 0;
    int              alleles_seen = 0;
    int              loci_seen = 0;
    int              results_checked = 0;

    function automatic longint limit_freq(logic [FREQ_W-1:0] f);
      return (f > 17'd65536) ? 64'sd65536 : longint'(f);
    endfunction

    // t * 2^FRAC / den, toward zero, saturated to the 24-bit range
    function automatic longint scale_quotient(longint t, longint unsigned den);
      bit              neg;
      longint unsigned mag, q, r, frac, m;
      neg  = t < 0;
      mag  = neg ? longint'(-t) : t;
      q    = mag / den;
      r    = mag % den;
      frac = (r << FRAC) / den;
      if (q > (64'd1 << 25)) q = 64'd1 << 25;
      m = (q << FRAC) + frac;
      if (neg) begin
        if (m >= 64'd8388608) return KIN_LO;
        return -longint'(m);
      end
      if (m > 64'd8388607) return KIN_HI;
      return longint'(m);
    endfunction

    function automatic void absorb_allele(pke_in_t it);
      longint          a, b, p;
      longint unsigned div;
      pke_out_t        due;
      a = limit_freq(it.freq_first);
      b = limit_freq(it.freq_second);
      p = limit_freq(it.ref_freq);
      alleles_seen++;
      product_acc += (a - p) * (b - p);
      if (product_acc > PSUM_HI) product_acc = PSUM_HI;
      if (product_acc < PSUM_LO) product_acc = PSUM_LO;
      variance_acc += longint'(p) * longint'(65536 - p);
      if (variance_acc > VSUM_HI) variance_acc = VSUM_HI;
      if (it.data_missing) missing_acc = 1'b1;
      if (!it.last_allele) return;
      due = '0;
      due.locus_missing = missing_acc;
      if (!missing_acc) begin
        if (variance_acc == 0) begin
          due.zero_denominator = 1'b1;
        end else begin
          div = (it.gene_copies < 2) ? 64'd1 : longint'(it.gene_copies) - 1;
          due.kinship = KIN_W'(scale_quotient(product_acc + longint'(variance_acc / div),
                                              variance_acc));
        end
      end
      loci_due.push_back(due);
      loci_seen++;
      product_acc  = 0;
      variance_acc = 0;
      missing_acc  = 1'b0;
    endfunction

    function automatic void compare_result(pke_out_t got);
      pke_out_t due;
      if (loci_due.size() == 0) begin
        $error("result with no locus pending: kinship %0d missing %0b zero_den %0b",
               got.kinship, got.locus_missing, got.zero_denominator);
        errors++;
        return;
      end
      due = loci_due.pop_front();
      results_checked++;
      if (got.kinship !== due.kinship) begin
        $error("kinship: expected %0d, actual %0d", due.kinship, got.kinship);
        errors++;
      end
      if (got.locus_missing !== due.locus_missing) begin
        $error("locus_missing: expected %0b, actual %0b",
               due.locus_missing, got.locus_missing);
        errors++;
      end
      if (got.zero_denominator !== due.zero_denominator) begin
        $error("zero_denominator: expected %0b, actual %0b",
               due.zero_denominator, got.zero_denominator);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  pke_in_t  item_drv = '0;
  logic     full;
  logic     empty;
  pke_out_t result_o;
  int       cycles = 0;

  kinship_scoreboard sb = new();

  pairwise_kinship_estimator_top #(
    .FRAC_BITS(FRAC_BITS_DEF)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_drv),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic pke_in_t make_allele(logic [FREQ_W-1:0] a, logic [FREQ_W-1:0] b,
                                          logic [FREQ_W-1:0] p, logic [COPIES_W-1:0] n,
                                          bit miss, bit last);
    pke_in_t it;
    it.freq_first   = a;
    it.freq_second  = b;
    it.ref_freq     = p;
    it.gene_copies  = n;
    it.data_missing = miss;
    it.last_allele  = last;
    return it;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FREQ_W'(65536);
      2:       return FREQ_W'($urandom_range(65537, 131071));
      default: return FREQ_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the transaction
  task automatic drive_item(input pke_in_t it, input int gap);
    bit stalled;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    item_drv <= it;
    do begin
      @(negedge clk_i);
      stalled = full;
      @(posedge clk_i);
    end while (stalled);
    sb.absorb_allele(it);
  endtask

  task automatic send_random_locus();
    int                  n, kind, miss_at, sel;
    bit                  burst, flat_ref;
    logic [COPIES_W-1:0] copies;
    logic [FREQ_W-1:0]   p;
    pke_in_t             it;
    kind = $urandom_range(0, 19);
    sel  = $urandom_range(0, 19);
    if (sel < 14)      n = $urandom_range(1, 6);
    else if (sel < 19) n = $urandom_range(7, 64);
    else               n = $urandom_range(65, 120);
    copies   = ($urandom_range(0, 3) == 0) ? COPIES_W'($urandom) :
                                             COPIES_W'($urandom_range(2, 300));
    miss_at  = (kind < 2) ? $urandom_range(0, n - 1) : -1;
    flat_ref = (kind == 3 || kind == 4);
    burst    = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (flat_ref) begin
        case ($urandom_range(0, 2))
          0:       p = '0;
          1:       p = FREQ_W'(65536);
          default: p = FREQ_W'($urandom_range(65537, 131071));
        endcase
      end else begin
        p = pick_freq();
      end
      it = make_allele(pick_freq(), pick_freq(), p, copies,
                       (i == miss_at) || (kind == 2 && $urandom_range(0, 3) == 0),
                       i == n - 1);
      drive_item(it, burst ? 0 : $urandom_range(0, 19));
    end
  endtask

  initial begin : result_sink
    int       gap, taken;
    bit       held, burst, was_empty;
    pke_out_t got;
    taken = 0;
    held  = 1'b0;
    burst = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      if (taken == 40 && !held) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk_i);
        was_empty = empty;
        got       = result_o;
        @(posedge clk_i);
      end while (was_empty);
      sb.compare_result(got);
      taken++;
    end
  end

  initial begin : item_source
    int first_random;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed loci
    drive_item(make_allele('0, '0, '0, 16'd2, 0, 1), 0);
    drive_item(make_allele(17'd65536, 17'd65536, '0, 16'd2, 0, 1), 3);
    drive_item(make_allele('1, '1, '1, 16'hFFFF, 0, 1), 0);
    drive_item(make_allele('0, 17'd65536, 17'd32768, 16'd0, 0, 1), 1);
    drive_item(make_allele(17'd65536, 17'd65536, 17'd1, 16'd1, 0, 1), 0);
    drive_item(make_allele(17'd65536, '0, 17'd65535, 16'hFFFF, 0, 1), 0);
    drive_item(make_allele(17'd40000, 17'd20000, 17'd30000, 16'd10, 0, 0), 0);
    drive_item(make_allele(17'd1000, 17'd70000, 17'd32768, 16'd10, 1, 0), 2);
    drive_item(make_allele(17'd65536, 17'd0, 17'd12345, 16'd10, 0, 1), 0);
    drive_item(make_allele(17'd500, 17'd500, '0, 16'd4, 0, 0), 0);
    drive_item(make_allele(17'd500, 17'd500, 17'd65536, 16'd4, 1, 1), 0);
    drive_item(make_allele(17'd32768, 17'd32768, 17'd32768, 16'd3, 0, 0), 0);
    drive_item(make_allele(17'd16384, 17'd49152, 17'd32768, 16'd3, 0, 1), 0);
    drive_item(make_allele(17'd65536, 17'd65536, 17'd32768, 16'd2, 0, 0), 5);
    drive_item(make_allele(17'd131071, 17'd0, 17'd65537, 16'd2, 0, 0), 0);
    drive_item(make_allele(17'd60000, 17'd61000, 17'd2000, 16'd2, 0, 1), 0);

    first_random = sb.alleles_seen;
    while (sb.alleles_seen < first_random + RANDOM_ITEMS) send_random_locus();
    push <= 1'b0;

    while (sb.loci_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d alleles in %0d loci; %0d results checked, %0d mismatches.",
             sb.alleles_seen, sb.loci_seen, sb.results_checked, sb.errors);
    $display("Included missing, zero-denominator, clamped and saturating loci.");
    if (sb.errors == 0 && sb.loci_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/pke_pkg.sv
rtl/core/pke_front.sv
rtl/core/pke_fifo.sv
rtl/core/pke_back.sv
rtl/core/pairwise_kinship_estimator_top.sv
tb/testbench.sv
